// ===== hw/rtl/sorted_table_binary_search_core_macros.svh =====
// Assertion macros shared by the sorted table search checker.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

// Check a property on clk; hold off while rst is high.
`define STBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on clk, also during reset.
`define STBS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/stbs_pkg.sv =====
// Shared constants, codes and types of the sorted table search core.
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int BOUND_W     = $clog2(TABLE_DEPTH + 1);

  // Fixed port widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_A_W = 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_FIRST = 2'd1;
  localparam logic [OP_W-1:0] OP_ANY   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_ENTRY_COUNT    = 1'd0;
  localparam logic [CFG_A_W-1:0] REG_COMPARE_SIGNED = 1'd1;

  // Search sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PROBE = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/stbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/sorted_table_binary_search_core.sv =====
// Sorted table search core: key table in RAM, halving search sequencer, output register.
//
// Usage:
//   Configuration: cfg_write_enable with cfg_index selects entry_count (0) or
//   compare_signed (1); write only while no search is in flight.
//   Input beat (in_valid/in_stall): operation, entry_index, key. A write
//   (operation 0) stores key at entry_index, no result; a search, first match
//   (1) or any match (2), returns one result beat; operation 3 is dropped.
//   Output beat (out_valid/out_stall): found, match_index (0 when not found).
// Timing:
//   Writes are taken back to back, one per cycle, while no search is in flight.
//   A search of s halving steps (at most 9 for 256 entries) passes through
//   ST_PROBE (read on the single RAM read port) and ST_CMP for each step; out_valid
//   rises when ST_DONE loads the result, and the next beat can be taken in the cycle after.
//   First-match mode then walks down in ST_WALK over each equal neighbour and
//   reads the entry below the run, unless the run reaches index 0.
//   in_stall stays high from the accepted search until its result loads into
//   the output register; a result waiting under out_stall holds the next
//   search in its last state but does not block writes.
// Reset: rst clears the sequencer state, configuration registers and out_valid; the table is not cleared.
module sorted_table_binary_search_core (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write_enable,
  input  logic [stbs_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [stbs_pkg::CFG_W-1:0]   cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [stbs_pkg::OP_W-1:0]    operation,
  input  logic [stbs_pkg::IDX_W-1:0]   entry_index,
  input  logic [stbs_pkg::KEY_W-1:0]   key,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [stbs_pkg::IDX_W-1:0]   match_index
);

  localparam int KW = stbs_pkg::KEY_WIDTH;
  localparam int AW = stbs_pkg::ADDR_W;
  localparam int BW = stbs_pkg::BOUND_W;

  // Configuration registers
  logic [stbs_pkg::CNT_W-1:0] entry_count;
  logic                       compare_signed;

  // Sequencer state
  stbs_pkg::state_t state, state_next;
  logic [BW-1:0]    lo, lo_next;
  logic [BW-1:0]    hi, hi_next;
  logic [AW-1:0]    probe, probe_next;
  logic [KW-1:0]    key_r;
  logic             first_mode;
  logic             res_found, res_found_next;
  logic [AW-1:0]    res_idx, res_idx_next;

  // RAM signals
  logic          ram_wr_en;
  logic [AW-1:0] ram_rd_addr;
  logic [KW-1:0] ram_rd_data;

  // Combinational helpers
  logic          accept;
  logic          is_search;
  logic          out_free;
  logic [BW-1:0] count_sat;
  logic [BW:0]   bound_sum;
  logic [AW-1:0] mid;
  logic [KW-1:0] key_in;
  logic [KW-1:0] cmp_a;
  logic [KW-1:0] cmp_b;
  logic          key_eq;
  logic          key_gt;
  logic [BW-1:0] probe_ext;
  logic [BW-1:0] probe_inc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != stbs_pkg::ST_IDLE);
  assign is_search = (operation == stbs_pkg::OP_FIRST) || (operation == stbs_pkg::OP_ANY);
  assign out_free  = !out_valid || !out_stall;
  assign key_in    = KW'(key);

  // Saturate the entry count to the table depth
  always_comb begin
    if (32'(entry_count) > 32'(stbs_pkg::TABLE_DEPTH)) begin
      count_sat = BW'(stbs_pkg::TABLE_DEPTH);
    end else begin
      count_sat = BW'(entry_count);
    end
  end

  // Midpoint of the half-open interval [lo, hi); it stays below the count
  assign bound_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = AW'(bound_sum >> 1);
  assign probe_ext = BW'(probe);
  assign probe_inc = probe_ext + BW'(1);

  // Compare the stored entry against the search key; flip sign bits for signed order
  assign cmp_a  = ram_rd_data ^ {compare_signed, {(KW-1){1'b0}}};
  assign cmp_b  = key_r ^ {compare_signed, {(KW-1){1'b0}}};
  assign key_eq = (cmp_a == cmp_b);
  assign key_gt = (cmp_a > cmp_b);

  // Writes only happen in idle and read data is only used during a search, so no forwarding
  assign ram_wr_en   = accept && (operation == stbs_pkg::OP_WRITE) &&
                       (32'(entry_index) < 32'(stbs_pkg::TABLE_DEPTH));
  assign ram_rd_addr = (state == stbs_pkg::ST_PROBE) ? mid : (probe - AW'(1));

  stbs_ram #(
    .WIDTH (KW),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (key_in),
    .rd_en   (1'b1),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count    <= '0;
      compare_signed <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        stbs_pkg::REG_ENTRY_COUNT:    entry_count    <= stbs_pkg::CNT_W'(cfg_data);
        stbs_pkg::REG_COMPARE_SIGNED: compare_signed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    probe_next     = probe;
    res_found_next = res_found;
    res_idx_next   = res_idx;
    case (state)
      stbs_pkg::ST_IDLE: begin
        if (accept && is_search) begin
          lo_next        = '0;
          hi_next        = count_sat;
          res_found_next = 1'b0;
          res_idx_next   = '0;
          if (count_sat == '0) begin
            state_next = stbs_pkg::ST_DONE;
          end else begin
            state_next = stbs_pkg::ST_PROBE;
          end
        end
      end
      stbs_pkg::ST_PROBE: begin
        probe_next = mid;
        state_next = stbs_pkg::ST_CMP;
      end
      stbs_pkg::ST_CMP: begin
        if (key_eq) begin
          if (first_mode && (probe != '0)) begin
            probe_next = probe - AW'(1);
            state_next = stbs_pkg::ST_WALK;
          end else begin
            res_found_next = 1'b1;
            res_idx_next   = probe;
            state_next     = stbs_pkg::ST_DONE;
          end
        end else if (key_gt) begin
          hi_next = probe_ext;
          if (lo < probe_ext) begin
            state_next = stbs_pkg::ST_PROBE;
          end else begin
            state_next = stbs_pkg::ST_DONE;
          end
        end else begin
          lo_next = probe_inc;
          if (probe_inc < hi) begin
            state_next = stbs_pkg::ST_PROBE;
          end else begin
            state_next = stbs_pkg::ST_DONE;
          end
        end
      end
      stbs_pkg::ST_WALK: begin
        // probe holds the neighbour just read; probe + 1 is a known match
        if (key_eq) begin
          if (probe == '0) begin
            res_found_next = 1'b1;
            res_idx_next   = '0;
            state_next     = stbs_pkg::ST_DONE;
          end else begin
            probe_next = probe - AW'(1);
          end
        end else begin
          res_found_next = 1'b1;
          res_idx_next   = probe + AW'(1);
          state_next     = stbs_pkg::ST_DONE;
        end
      end
      stbs_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search datapath registers
  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    probe     <= probe_next;
    res_found <= res_found_next;
    res_idx   <= res_idx_next;
    if (accept) begin
      key_r      <= key_in;
      first_mode <= (operation == stbs_pkg::OP_FIRST);
    end
  end

  // Output register: load a finished result, drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == stbs_pkg::ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == stbs_pkg::ST_DONE) && out_free) begin
      found       <= res_found;
      match_index <= stbs_pkg::IDX_W'(res_idx);
    end
  end

endmodule

// ===== hw/rtl/sorted_table_binary_search_core_checker.sv =====
// Port-level checker for the sorted table search core, bound to sorted_table_binary_search_core.
`include "sorted_table_binary_search_core_macros.svh"

module sorted_table_binary_search_core_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [stbs_pkg::OP_W-1:0]    operation,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         found,
  input logic [stbs_pkg::IDX_W-1:0]   match_index
);

  logic                     search_beat;
  logic [stbs_pkg::IDX_W:0] out_payload;

  // Accepted search beat and the full result payload
  assign search_beat = in_valid && !in_stall &&
                       (operation == stbs_pkg::OP_FIRST || operation == stbs_pkg::OP_ANY);
  assign out_payload = {found, match_index};

  // A stalled result beat stays valid
  `STBS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")

  // A stalled result beat keeps its payload
  `STBS_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_payload), "payload changed")

  // A miss reports index zero
  `STBS_ASSERT(a_miss_index, out_valid && !found |-> match_index == '0, "miss with nonzero index")

  // An accepted search blocks the input in the next cycle
  `STBS_ASSERT(a_search_busy, search_beat |=> in_stall, "search did not block input")

  // Reset leaves no result pending
  `STBS_ASSERT_RST(a_reset_clear, rst |=> !out_valid, "result valid after reset")

endmodule

bind sorted_table_binary_search_core sorted_table_binary_search_core_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .operation   (operation),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .match_index (match_index)
);

// ===== sim/stbs_result_checker.sv =====
// Result checker for the sorted table search core: tracks table and registers, predicts lookups.
`timescale 1ns / 100ps

module stbs_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write_enable,
  input  logic [stbs_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [stbs_pkg::CFG_W-1:0]   cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [stbs_pkg::OP_W-1:0]    operation,
  input  logic [stbs_pkg::IDX_W-1:0]   entry_index,
  input  logic [stbs_pkg::KEY_W-1:0]   key,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         found,
  input  logic [stbs_pkg::IDX_W-1:0]   match_index,
  output int                           mismatch_count,
  output int                           pending_results,
  output int                           results_checked
);

  typedef struct packed {
    logic                       hit;
    logic [stbs_pkg::IDX_W-1:0] index;
  } lookup_answer_t;

  // Mirror of the block's table and registers
  logic [stbs_pkg::KEY_W-1:0] key_table [stbs_pkg::TABLE_DEPTH];
  logic [stbs_pkg::CNT_W-1:0] entry_count_q;
  logic                       compare_signed_q;

  // Answers of accepted searches, oldest first
  lookup_answer_t   lookup_answers_q [$];
  int               fails;
  int               answers_seen;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
    results_checked = 0;
    fails           = 0;
    answers_seen    = 0;
  end

  // Order of stored entry a against searched key b: -1 below, 0 equal, 1 above
  function automatic int key_order(logic [stbs_pkg::KEY_W-1:0] a,
                                   logic [stbs_pkg::KEY_W-1:0] b);
    logic [stbs_pkg::KEY_W-1:0] ra;
    logic [stbs_pkg::KEY_W-1:0] rb;
    ra = a;
    rb = b;
    // flip the sign bit so two's complement order becomes unsigned order
    if (compare_signed_q) begin
      ra[stbs_pkg::KEY_W-1] = ~ra[stbs_pkg::KEY_W-1];
      rb[stbs_pkg::KEY_W-1] = ~rb[stbs_pkg::KEY_W-1];
    end
    if (ra < rb) return -1;
    if (ra > rb) return 1;
    return 0;
  endfunction

  // Halve [0, count) until a midpoint matches; first-match mode walks back over ties
  function automatic lookup_answer_t lookup_answer(logic [stbs_pkg::OP_W-1:0] op,
                                                   logic [stbs_pkg::KEY_W-1:0] k);
    lookup_answer_t r;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    int unsigned    where;
    int             c;
    r     = '0;
    where = 0;
    lo    = 0;
    hi    = (entry_count_q > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH
                                                    : entry_count_q;
    while (lo < hi && !r.hit) begin
      mid = (lo + hi) / 2;
      c   = key_order(key_table[mid], k);
      if (c == 0) begin
        r.hit = 1'b1;
        where = mid;
      end else if (c > 0) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    if (r.hit && op == stbs_pkg::OP_FIRST) begin
      while (where > 0 && key_order(key_table[where-1], k) == 0)
        where--;
    end
    r.index = where[stbs_pkg::IDX_W-1:0];
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    fails++;
    if (fails <= 10)
      $display("ERROR %t search %0d: %s expected %0d got %0d", $realtime, answers_seen,
               field, want, got);
  endtask

  always @(posedge clk) begin : watch
    lookup_answer_t want;
    if (rst) begin
      entry_count_q    = '0;
      compare_signed_q = 1'b0;
      lookup_answers_q.delete();
    end else begin
      // track register writes
      if (cfg_write_enable) begin
        if (cfg_index == stbs_pkg::REG_ENTRY_COUNT)
          entry_count_q = cfg_data;
        else if (cfg_index == stbs_pkg::REG_COMPARE_SIGNED)
          compare_signed_q = cfg_data[0];
      end
      // apply an accepted input beat
      if (in_valid && !in_stall) begin
        if (operation == stbs_pkg::OP_WRITE)
          key_table[entry_index] = key;
        else if (operation == stbs_pkg::OP_FIRST || operation == stbs_pkg::OP_ANY)
          lookup_answers_q.push_back(lookup_answer(operation, key));
      end
      // compare an accepted result beat with the oldest answer
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (lookup_answers_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("ERROR %t result beat with no search outstanding: found %0b index %0d",
                     $realtime, found, match_index);
        end else begin
          want = lookup_answers_q.pop_front();
          if (found !== want.hit)
            note_mismatch("found", want.hit, found);
          if (match_index !== want.index)
            note_mismatch("match_index", want.index, match_index);
        end
      end
    end
    pending_results <= lookup_answers_q.size();
    mismatch_count  <= fails;
    results_checked <= answers_seen;
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the sorted table search testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [stbs_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int unsigned               ITEM_TARGET = 1950;
  localparam int unsigned               TAIL_BEATS  = 250;

  logic                         clk              = 1'b0;
  logic                         rst              = 1'b1;
  logic                         cfg_write_enable = 1'b0;
  logic [stbs_pkg::CFG_A_W-1:0] cfg_index        = '0;
  logic [stbs_pkg::CFG_W-1:0]   cfg_data         = '0;
  logic                         in_valid         = 1'b0;
  logic                         in_stall;
  logic [stbs_pkg::OP_W-1:0]    operation        = '0;
  logic [stbs_pkg::IDX_W-1:0]   entry_index      = '0;
  logic [stbs_pkg::KEY_W-1:0]   key              = '0;
  logic                         out_valid;
  logic                         out_stall        = 1'b0;
  logic                         found;
  logic [stbs_pkg::IDX_W-1:0]   match_index;

  int                 mismatch_count;
  int                 pending_results;
  int                 results_checked;

  // Keys last written at each position, used to aim searches at present keys
  logic [stbs_pkg::KEY_W-1:0] loaded_keys [stbs_pkg::TABLE_DEPTH];
  int unsigned        beats_sent  = 0;
  int unsigned        phases_run  = 0;
  bit                 tail_quiet  = 1'b0;
  bit                 calm        = 1'b0;
  int unsigned        calm_left   = 200;
  int unsigned        stall_left  = 0;

  sorted_table_binary_search_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .entry_index      (entry_index),
    .key              (key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .match_index      (match_index)
  );

  stbs_result_checker chk (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .entry_index      (entry_index),
    .key              (key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .found            (found),
    .match_index      (match_index),
    .mismatch_count   (mismatch_count),
    .pending_results  (pending_results),
    .results_checked  (results_checked)
  );

  always #5 clk = ~clk;

  // Alternate stretches with and without idling
  always @(posedge clk) begin
    if (calm_left != 0) begin
      calm_left <= calm_left - 1;
    end else begin
      calm      <= ~calm;
      calm_left <= $urandom_range(60, 400);
    end
  end

  // Stall the result channel in bursts of random length
  always @(posedge clk) begin
    if (rst || tail_quiet || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 14);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Offer one input beat, possibly after a gap, and hold it until accepted
  task automatic send_beat(input logic [stbs_pkg::OP_W-1:0] op,
                           input logic [stbs_pkg::IDX_W-1:0] idx,
                           input logic [stbs_pkg::KEY_W-1:0] k);
    if (!calm && !tail_quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    entry_index <= idx;
    key         <= k;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (op == stbs_pkg::OP_WRITE)
      loaded_keys[idx] = k;
    if (op != OP_UNUSED)
      beats_sent++;
    if (beats_sent + TAIL_BEATS >= ITEM_TARGET)
      tail_quiet = 1'b1;
  endtask

  // Drop valid and hold until every search has answered, then let writes settle
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned entries, input bit signed_mode);
    cfg_write_enable <= 1'b1;
    cfg_index        <= stbs_pkg::REG_ENTRY_COUNT;
    cfg_data         <= stbs_pkg::CFG_W'(entries);
    @(posedge clk);
    cfg_index        <= stbs_pkg::REG_COMPARE_SIGNED;
    cfg_data         <= stbs_pkg::CFG_W'(signed_mode);
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // Fill positions [0, span) with keys non-decreasing in the chosen compare order
  task automatic load_sorted(input int unsigned span, input bit signed_mode);
    longint unsigned            ord;
    int unsigned                step_max;
    logic [stbs_pkg::KEY_W-1:0] k;
    step_max = ($urandom_range(0, 2) == 0) ? 2 : (1 << $urandom_range(4, 26));
    ord      = longint'($urandom) >> $urandom_range(0, 32);
    for (int unsigned i = 0; i < span; i++) begin
      k = (ord > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ord[31:0];
      if (signed_mode)
        k[stbs_pkg::KEY_W-1] = ~k[stbs_pkg::KEY_W-1];
      send_beat(stbs_pkg::OP_WRITE, stbs_pkg::IDX_W'(i), k);
      ord += $urandom_range(0, step_max);
    end
  endtask

  // Mostly keys that are present, else near misses, extremes and noise
  function automatic logic [stbs_pkg::KEY_W-1:0] pick_search_key(input int unsigned span);
    logic [stbs_pkg::KEY_W-1:0] k;
    k = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: if (span != 0) k = loaded_keys[$urandom_range(0, span - 1)];
      6: if (span != 0) begin
        k = loaded_keys[$urandom_range(0, span - 1)];
        k = $urandom_range(0, 1) ? k + 1 : k - 1;
      end
      7: case ($urandom_range(0, 3))
        0: k = 32'h0000_0000;
        1: k = 32'hFFFF_FFFF;
        2: k = 32'h7FFF_FFFF;
        default: k = 32'h8000_0000;
      endcase
      default: ;
    endcase
    return k;
  endfunction

  task automatic random_beat(input int unsigned span);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0)
      send_beat(OP_UNUSED, stbs_pkg::IDX_W'($urandom), $urandom);
    else if (pick == 1)
      send_beat(stbs_pkg::OP_WRITE, stbs_pkg::IDX_W'($urandom), $urandom);
    else
      send_beat(pick[0] ? stbs_pkg::OP_FIRST : stbs_pkg::OP_ANY,
                stbs_pkg::IDX_W'($urandom), pick_search_key(span));
  endtask

  initial begin
    int unsigned entries;
    int unsigned span;
    bit          signed_mode;
    int unsigned waited;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table and the unused operation
    send_beat(stbs_pkg::OP_FIRST, 8'd0, 32'h0000_0000);
    send_beat(stbs_pkg::OP_ANY, 8'hFF, 32'hFFFF_FFFF);
    send_beat(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);

    // small table with a run of equal keys and both ends of the key range
    send_beat(stbs_pkg::OP_WRITE, 8'd0, 32'h0000_0000);
    send_beat(stbs_pkg::OP_WRITE, 8'd1, 32'h0000_0005);
    send_beat(stbs_pkg::OP_WRITE, 8'd2, 32'h0000_0005);
    send_beat(stbs_pkg::OP_WRITE, 8'd3, 32'h0000_0005);
    send_beat(stbs_pkg::OP_WRITE, 8'd4, 32'h7FFF_FFFF);
    send_beat(stbs_pkg::OP_WRITE, 8'd5, 32'hFFFF_FFFF);
    send_beat(stbs_pkg::OP_WRITE, 8'hFF, 32'hA5A5_A5A5);
    wait_for_idle();
    set_config(6, 1'b0);
    send_beat(stbs_pkg::OP_FIRST, 8'd0, 32'h0000_0005);
    send_beat(stbs_pkg::OP_ANY, 8'd0, 32'h0000_0005);
    send_beat(stbs_pkg::OP_FIRST, 8'd0, 32'h0000_0000);
    send_beat(stbs_pkg::OP_ANY, 8'd0, 32'hFFFF_FFFF);
    send_beat(stbs_pkg::OP_FIRST, 8'd0, 32'h7FFF_FFFF);
    send_beat(stbs_pkg::OP_ANY, 8'd0, 32'h0000_0006);
    send_beat(stbs_pkg::OP_FIRST, 8'd0, 32'h8000_0000);

    // same table read in two's complement order is no longer sorted
    wait_for_idle();
    set_config(6, 1'b1);
    send_beat(stbs_pkg::OP_FIRST, 8'd0, 32'hFFFF_FFFF);
    send_beat(stbs_pkg::OP_ANY, 8'd0, 32'h8000_0000);

    // random phases: full table with saturated count first, then mostly small tables
    while (beats_sent < ITEM_TARGET) begin
      if (phases_run == 0)
        entries = 511;
      else if (phases_run == 1)
        entries = 256;
      else if ($urandom_range(0, 11) == 0)
        entries = $urandom_range(256, 511);
      else
        entries = $urandom_range(0, 40);
      span        = (entries > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : entries;
      signed_mode = (phases_run == 1) ? 1'b1 : 1'($urandom_range(0, 1));
      wait_for_idle();
      set_config(entries, signed_mode);
      load_sorted(span, signed_mode);
      repeat ($urandom_range(30, 70)) random_beat(span);
      phases_run++;
    end

    // drain
    in_valid <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (pending_results != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);

    $display("Covered %0d input beats over %0d table setups, counts 0 to 511, both orders",
             beats_sent, phases_run);
    $display("Checked %0d search results, %0d still outstanding",
             results_checked, pending_results);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(64'd60_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
